// ===== hdl/psd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

  // Store geometry and field widths.
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int MAX_FRAMES = 4;
  localparam int CHANNELS   = 3;
  localparam int MAX_RADIUS = 15;

  localparam int COL_W   = 7;
  localparam int ROW_W   = 7;
  localparam int FRAME_W = 2;
  localparam int ADDR_W  = FRAME_W + ROW_W + COL_W;
  localparam int PIX_W   = 24;
  localparam int CHAN_W  = 8;
  localparam int DIM_W   = 8;
  localparam int RAD_W   = 4;
  localparam int DIST_W  = 28;
  localparam int SQ_W    = 2 * CHAN_W;
  localparam int SQSUM_W = SQ_W + 2;
  localparam int OFS_W   = 9;

  localparam logic [DIST_W-1:0] ALL_ONES = {DIST_W{1'b1}};

  // Function codes of an input word.
  localparam logic [1:0] FUNC_WR_SRC = 2'd0;
  localparam logic [1:0] FUNC_WR_TGT = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  typedef enum logic [1:0] {
    OUT_VALID   = 2'd0,
    OUT_REJECT  = 2'd1,
    OUT_OVERRUN = 2'd2
  } psd_outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } psd_state_t;

  typedef struct packed {
    logic [FRAME_W-1:0] sf;
    logic [COL_W-1:0]   sx;
    logic [ROW_W-1:0]   sy;
    logic [FRAME_W-1:0] tf;
    logic [COL_W-1:0]   tx;
    logic [ROW_W-1:0]   ty;
    logic [DIST_W-1:0]  thr;
  } psd_query_t;

  // Saturated register values.
  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [RAD_W-1:0] r;
  } psd_cfg_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] tgt_addr;
  } psd_rd_t;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] distance;
    psd_outcome_t      outcome;
  } psd_result_t;

endpackage

`default_nettype wire

// ===== hdl/psd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module psd_ram #(
  parameter int DATA_W = 24,
  parameter int ADDR_W = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/psd_window.sv =====
`timescale 1ns / 1ps
`default_nettype none

module psd_window (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire psd_pkg::psd_query_t       query,
  input  wire psd_pkg::psd_cfg_t         cfg,
  output psd_pkg::psd_rd_t               rd,
  input  wire logic [psd_pkg::PIX_W-1:0] src_data,
  input  wire logic [psd_pkg::PIX_W-1:0] tgt_data,
  input  wire logic                      res_take,
  output psd_pkg::psd_result_t           res,
  output logic                           busy
);

  import psd_pkg::*;

  psd_state_t st, st_next;
  psd_query_t q;
  logic signed [OFS_W-1:0] x, y, x1, x2, y2;
  logic signed [OFS_W-1:0] x_next, y_next;
  logic reject, reject_next;
  logic rd_v, sq_v;
  logic [SQ_W-1:0] sq [CHANNELS];
  logic [DIST_W-1:0] acc;

  logic signed [OFS_W-1:0] bx1, bx2, by1, by2;
  logic signed [OFS_W+1:0] w_lim, h_lim, tx_s, ty_s, r_s;
  logic too_near, empty;
  logic signed [OFS_W-1:0] s_col, s_row, t_col, t_row;
  logic [SQSUM_W-1:0] sq_sum;

  function automatic logic signed [OFS_W-1:0] smax(input logic signed [OFS_W-1:0] a,
                                                    input logic signed [OFS_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [OFS_W-1:0] smin(input logic signed [OFS_W-1:0] a,
                                                    input logic signed [OFS_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // Edge test of the target centre. A target that passes keeps its whole
  // window inside the frame, so only the source side clips the window.
  always_comb begin
    r_s   = $signed({{(OFS_W+2-RAD_W){1'b0}}, cfg.r});
    tx_s  = $signed({{(OFS_W+2-COL_W){1'b0}}, q.tx});
    ty_s  = $signed({{(OFS_W+2-ROW_W){1'b0}}, q.ty});
    w_lim = $signed({{(OFS_W+2-DIM_W){1'b0}}, cfg.w}) - r_s;
    h_lim = $signed({{(OFS_W+2-DIM_W){1'b0}}, cfg.h}) - r_s;
    too_near = (tx_s < r_s) || (tx_s >= w_lim) || (ty_s < r_s) || (ty_s >= h_lim);
    bx1 = smax(-$signed({{(OFS_W-RAD_W){1'b0}}, cfg.r}),
               -$signed({{(OFS_W-COL_W){1'b0}}, q.sx}));
    bx2 = smin($signed({{(OFS_W-RAD_W){1'b0}}, cfg.r}),
               $signed({1'b0, cfg.w}) - 9'sd1 - $signed({{(OFS_W-COL_W){1'b0}}, q.sx}));
    by1 = smax(-$signed({{(OFS_W-RAD_W){1'b0}}, cfg.r}),
               -$signed({{(OFS_W-ROW_W){1'b0}}, q.sy}));
    by2 = smin($signed({{(OFS_W-RAD_W){1'b0}}, cfg.r}),
               $signed({1'b0, cfg.h}) - 9'sd1 - $signed({{(OFS_W-ROW_W){1'b0}}, q.sy}));
    empty = (bx1 > bx2) || (by1 > by2);
  end

  // Pixel addresses of the current window offset.
  always_comb begin
    s_col = $signed({{(OFS_W-COL_W){1'b0}}, q.sx}) + x;
    s_row = $signed({{(OFS_W-ROW_W){1'b0}}, q.sy}) + y;
    t_col = $signed({{(OFS_W-COL_W){1'b0}}, q.tx}) + x;
    t_row = $signed({{(OFS_W-ROW_W){1'b0}}, q.ty}) + y;
    rd.en       = (st == ST_SCAN);
    rd.src_addr = {q.sf, s_row[ROW_W-1:0], s_col[COL_W-1:0]};
    rd.tgt_addr = {q.tf, t_row[ROW_W-1:0], t_col[COL_W-1:0]};
  end

  // Next state, scan counters and result.
  always_comb begin
    st_next     = st;
    x_next      = x;
    y_next      = y;
    reject_next = reject;
    res.valid    = 1'b0;
    res.distance = acc;
    res.outcome  = OUT_VALID;
    case (st)
      ST_IDLE: begin
        if (start) begin
          st_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        x_next      = bx1;
        y_next      = by1;
        reject_next = too_near;
        if (too_near || empty) begin
          st_next = ST_DONE;
        end else begin
          st_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (x == x2) begin
          x_next = x1;
          if (y == y2) begin
            st_next = ST_DRAIN;
          end else begin
            y_next = y + 9'sd1;
          end
        end else begin
          x_next = x + 9'sd1;
        end
      end
      ST_DRAIN: begin
        if (!rd_v && !sq_v) begin
          st_next = ST_DONE;
        end
      end
      ST_DONE: begin
        res.valid = 1'b1;
        if (reject) begin
          res.distance = ALL_ONES;
          res.outcome  = OUT_REJECT;
        end else if (q.thr != ALL_ONES && acc > q.thr) begin
          res.distance = ALL_ONES;
          res.outcome  = OUT_OVERRUN;
        end
        if (res_take) begin
          st_next = ST_IDLE;
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (st != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // Sum of the per-channel squares of one pixel pair.
  always_comb begin
    sq_sum = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      sq_sum = sq_sum + SQSUM_W'(sq[ch]);
    end
  end

  // Query latch, counters and the read, square, accumulate pipeline.
  // The largest window sum stays below the 28-bit ceiling.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      sq_v <= 1'b0;
    end else begin
      rd_v <= (st == ST_SCAN);
      sq_v <= rd_v;
    end
    if (st == ST_IDLE && start) begin
      q <= query;
    end
    if (st == ST_SETUP) begin
      x1  <= bx1;
      x2  <= bx2;
      y2  <= by2;
      acc <= '0;
    end else if (sq_v) begin
      acc <= acc + DIST_W'(sq_sum);
    end
    x      <= x_next;
    y      <= y_next;
    reject <= reject_next;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      logic [CHAN_W-1:0] a, b, ad;
      a  = src_data[CHAN_W*ch +: CHAN_W];
      b  = tgt_data[CHAN_W*ch +: CHAN_W];
      ad = (a > b) ? (a - b) : (b - a);
      if (rd_v) begin
        sq[ch] <= ad * ad;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/patch_ssd_distance_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake              Word
// in        input      in_valid / in_stall    func, frame, col, row, pixel, target fields
// out       output     out_valid / out_stall  distance, outcome
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A pixel write goes straight into its frame memory. A query scans the n pixels
// of the clipped window (49 for radius 3): the scan reads one packed source and
// target pixel pair per cycle from the two frame memories.
// Reset clears control state and loads the registers; the frame memories are
// undefined until written and need no clearing pass.
// in_stall is high from an accepted query until its result moves into the
// output register; a finished result waits there while new words are taken.

module patch_ssd_distance_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    func,
  input  wire logic [psd_pkg::FRAME_W-1:0]   frame,
  input  wire logic [psd_pkg::COL_W-1:0]     col,
  input  wire logic [psd_pkg::ROW_W-1:0]     row,
  input  wire logic [psd_pkg::PIX_W-1:0]     pixel,
  input  wire logic [psd_pkg::FRAME_W-1:0]   target_frame,
  input  wire logic [psd_pkg::COL_W-1:0]     target_col,
  input  wire logic [psd_pkg::ROW_W-1:0]     target_row,
  input  wire logic [psd_pkg::DIST_W-1:0]    threshold,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [psd_pkg::DIST_W-1:0]         distance,
  output logic [1:0]                         outcome,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [psd_pkg::DIM_W-1:0]     cfg_data
);

  import psd_pkg::*;

  localparam logic [DIM_W-1:0] MAX_W = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H = DIM_W'(MAX_HEIGHT);

  logic [DIM_W-1:0] frame_width, frame_height;
  logic [RAD_W-1:0] patch_radius;
  psd_cfg_t cfg;
  psd_query_t query;
  psd_rd_t rd;
  psd_result_t res;
  logic win_busy, in_accept, src_we, tgt_we, start, res_take;
  logic [ADDR_W-1:0] waddr;
  logic [PIX_W-1:0] src_data, tgt_data;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= MAX_W;
      frame_height <= MAX_H;
      patch_radius <= RAD_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH:  frame_width  <= cfg_data;
        REG_HEIGHT: frame_height <= cfg_data;
        REG_RADIUS: patch_radius <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the frame size and the radius into their legal ranges.
  always_comb begin
    cfg.w = (frame_width == '0) ? DIM_W'(1) : ((frame_width > MAX_W) ? MAX_W : frame_width);
    cfg.h = (frame_height == '0) ? DIM_W'(1) :
            ((frame_height > MAX_H) ? MAX_H : frame_height);
    cfg.r = (patch_radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : patch_radius;
  end

  // Input word decode.
  assign in_stall  = win_busy;
  assign in_accept = in_valid && !in_stall;
  assign src_we    = in_accept && (func == FUNC_WR_SRC);
  assign tgt_we    = in_accept && (func == FUNC_WR_TGT);
  assign start     = in_accept && (func == FUNC_QUERY);
  assign waddr     = {frame, row, col};

  always_comb begin
    query.sf  = frame;
    query.sx  = col;
    query.sy  = row;
    query.tf  = target_frame;
    query.tx  = target_col;
    query.ty  = target_row;
    query.thr = threshold;
  end

  psd_ram #(.DATA_W(PIX_W), .ADDR_W(ADDR_W)) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (waddr),
    .wdata (pixel),
    .re    (rd.en),
    .raddr (rd.src_addr),
    .rdata (src_data)
  );

  psd_ram #(.DATA_W(PIX_W), .ADDR_W(ADDR_W)) u_tgt_ram (
    .clk   (clk),
    .we    (tgt_we),
    .waddr (waddr),
    .wdata (pixel),
    .re    (rd.en),
    .raddr (rd.tgt_addr),
    .rdata (tgt_data)
  );

  psd_window u_window (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .query    (query),
    .cfg      (cfg),
    .rd       (rd),
    .src_data (src_data),
    .tgt_data (tgt_data),
    .res_take (res_take),
    .res      (res),
    .busy     (win_busy)
  );

  // Output register, loaded with a ready result whenever it is empty or being emptied.
  assign res_take = res.valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_take) begin
      distance <= res.distance;
      outcome  <= res.outcome;
    end
  end

`ifndef SYNTHESIS
  // An accepted query holds off the input on the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> in_stall)
    else $error("query accepted without holding off input");

  // Memories are never written while a scan reads them.
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (src_we || tgt_we) |-> !rd.en)
    else $error("frame write during a scan");

  // Rejected and overrun results carry an all-ones distance.
  a_flag_ones: assert property (@(posedge clk) disable iff (rst)
    (out_valid && outcome != OUT_VALID) |-> (distance == ALL_ONES))
    else $error("flagged result without all-ones distance");

  // A result is handed over only after the window unit finished.
  a_take_done: assert property (@(posedge clk) disable iff (rst)
    res_take |=> !win_busy || start)
    else $error("window unit still busy after its result was taken");
`endif

endmodule

`default_nettype wire

// ===== test/patch_ssd_distance_top_tb.sv =====
`timescale 1ns / 1ps

module patch_ssd_distance_top_tb;
  import psd_pkg::*;

  // Function code that the block must ignore.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 600;
  localparam int CYCLE_LIMIT   = 2000000;

  // One input word as it appears on the ports.
  typedef struct packed {
    logic [1:0]         func;
    logic [FRAME_W-1:0] frame;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [PIX_W-1:0]   pixel;
    logic [FRAME_W-1:0] target_frame;
    logic [COL_W-1:0]   target_col;
    logic [ROW_W-1:0]   target_row;
    logic [DIST_W-1:0]  threshold;
  } ssd_word_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    psd_outcome_t      outcome;
  } ssd_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid = 1'b0;
  logic              in_stall;
  ssd_word_t         word_now = '0;
  logic [1:0]        func;
  logic [FRAME_W-1:0] frame;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [PIX_W-1:0]  pixel;
  logic [FRAME_W-1:0] target_frame;
  logic [COL_W-1:0]  target_col;
  logic [ROW_W-1:0]  target_row;
  logic [DIST_W-1:0] threshold;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DIST_W-1:0] distance;
  logic [1:0]        outcome;

  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [DIM_W-1:0]  cfg_data = '0;

  assign func         = word_now.func;
  assign frame        = word_now.frame;
  assign col          = word_now.col;
  assign row          = word_now.row;
  assign pixel        = word_now.pixel;
  assign target_frame = word_now.target_frame;
  assign target_col   = word_now.target_col;
  assign target_row   = word_now.target_row;
  assign threshold    = word_now.threshold;

  patch_ssd_distance_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .frame(frame), .col(col), .row(row), .pixel(pixel),
    .target_frame(target_frame), .target_col(target_col), .target_row(target_row),
    .threshold(threshold),
    .out_valid(out_valid), .out_stall(out_stall),
    .distance(distance), .outcome(outcome),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the block: register copies and the two frame stores.
  logic [DIM_W-1:0] reg_w = 8'd128;
  logic [DIM_W-1:0] reg_h = 8'd128;
  logic [RAD_W-1:0] reg_r = 4'd3;
  bit [PIX_W-1:0]   src_mem [0:65535];
  bit [PIX_W-1:0]   tgt_mem [0:65535];

  // Pixels already queued for writing, so a query never reads an unwritten entry.
  bit src_written [0:65535];
  bit tgt_written [0:65535];

  ssd_word_t   pending_words [$];
  ssd_result_t expected_ssd [$];

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  logic hold_go = 1'b0;
  logic hold_taken = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;

  int fail_count = 0;
  int words_taken = 0;
  int queries_taken = 0;
  int rejects_seen = 0;
  int overruns_seen = 0;
  int results_seen = 0;
  int reg_writes = 0;

  function automatic int eff_w();
    int v;
    v = reg_w;
    if (v < 1) v = 1;
    if (v > MAX_WIDTH) v = MAX_WIDTH;
    return v;
  endfunction

  function automatic int eff_h();
    int v;
    v = reg_h;
    if (v < 1) v = 1;
    if (v > MAX_HEIGHT) v = MAX_HEIGHT;
    return v;
  endfunction

  function automatic bit too_near_edge(input int tx, input int ty);
    int r;
    r = reg_r;
    return (tx < r) || (tx >= eff_w() - r) || (ty < r) || (ty >= eff_h() - r);
  endfunction

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int imin(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  // Window offsets that keep both patches inside the active frame.
  function automatic void clip_window(input int sx, input int sy, input int tx, input int ty,
                                      output int x1, output int x2,
                                      output int y1, output int y2);
    int r;
    r = reg_r;
    x1 = imax(-r, imax(-sx, -tx));
    x2 = imin(r, imin(eff_w() - 1 - sx, eff_w() - 1 - tx));
    y1 = imax(-r, imax(-sy, -ty));
    y2 = imin(r, imin(eff_h() - 1 - sy, eff_h() - 1 - ty));
  endfunction

  function automatic logic [15:0] pix_addr(input logic [1:0] f, input int c, input int r);
    return {f, r[6:0], c[6:0]};
  endfunction

  // Sum of squared channel differences for one query word, with its reject or overrun outcome.
  function automatic ssd_result_t patch_distance(input ssd_word_t q);
    int x1, x2, y1, y2, x, y, ch, d;
    longint sum;
    bit [PIX_W-1:0] sp, tp;
    ssd_result_t res;
    if (too_near_edge(q.target_col, q.target_row)) begin
      res.distance = ALL_ONES;
      res.outcome = OUT_REJECT;
      return res;
    end
    clip_window(q.col, q.row, q.target_col, q.target_row, x1, x2, y1, y2);
    sum = 0;
    for (y = y1; y <= y2; y++) begin
      for (x = x1; x <= x2; x++) begin
        sp = src_mem[pix_addr(q.frame, q.col + x, q.row + y)];
        tp = tgt_mem[pix_addr(q.target_frame, q.target_col + x, q.target_row + y)];
        for (ch = 0; ch < CHANNELS; ch++) begin
          d = int'(sp[8*ch +: 8]) - int'(tp[8*ch +: 8]);
          sum += d * d;
        end
      end
    end
    if (sum > ALL_ONES) sum = ALL_ONES;
    if (q.threshold != ALL_ONES && sum > q.threshold) begin
      res.distance = ALL_ONES;
      res.outcome = OUT_OVERRUN;
    end else begin
      res.distance = sum[DIST_W-1:0];
      res.outcome = OUT_VALID;
    end
    return res;
  endfunction

  // Update the shadow for one accepted input word.
  function automatic void take_word(input ssd_word_t w);
    ssd_result_t res;
    words_taken++;
    case (w.func)
      FUNC_WR_SRC: src_mem[pix_addr(w.frame, w.col, w.row)] = w.pixel;
      FUNC_WR_TGT: tgt_mem[pix_addr(w.frame, w.col, w.row)] = w.pixel;
      FUNC_QUERY: begin
        res = patch_distance(w);
        queries_taken++;
        if (res.outcome == OUT_REJECT) rejects_seen++;
        if (res.outcome == OUT_OVERRUN) overruns_seen++;
        expected_ssd.push_back(res);
      end
      default: ;
    endcase
  endfunction

  function automatic void apply_reg(input logic [1:0] idx, input logic [DIM_W-1:0] data);
    reg_writes++;
    case (idx)
      REG_WIDTH:  reg_w = data;
      REG_HEIGHT: reg_h = data;
      REG_RADIUS: reg_r = data[RAD_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, msg);
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DIST_W-1:0] random_threshold();
    case ($urandom_range(0, 3))
      0: return ALL_ONES;
      1: return $urandom;
      2: return $urandom_range(0, 4000);
      default: return $urandom_range(0, 300000);
    endcase
  endfunction

  function automatic ssd_word_t pack_word(input logic [1:0] fn, input logic [1:0] f,
                                          input int c, input int r,
                                          input logic [PIX_W-1:0] pix,
                                          input logic [1:0] tf, input int tc, input int tr,
                                          input logic [DIST_W-1:0] thr);
    ssd_word_t w;
    w.func = fn;
    w.frame = f;
    w.col = c[6:0];
    w.row = r[6:0];
    w.pixel = pix;
    w.target_frame = tf;
    w.target_col = tc[6:0];
    w.target_row = tr[6:0];
    w.threshold = thr;
    return w;
  endfunction

  // Pixel write; the target fields and threshold carry noise.
  task automatic queue_write(input logic [1:0] fn, input logic [1:0] f, input int c,
                             input int r, input logic [PIX_W-1:0] pix);
    if (fn == FUNC_WR_SRC) src_written[pix_addr(f, c, r)] = 1'b1;
    if (fn == FUNC_WR_TGT) tgt_written[pix_addr(f, c, r)] = 1'b1;
    pending_words.push_back(pack_word(fn, f, c, r, pix, $urandom, $urandom, $urandom,
                                      $urandom));
  endtask

  // Query, preceded by writes of any window pixel not yet loaded.
  task automatic queue_query(input logic [1:0] sf, input int sx, input int sy,
                             input logic [1:0] tf, input int tx, input int ty,
                             input logic [DIST_W-1:0] thr);
    int x1, x2, y1, y2, x, y;
    if (!too_near_edge(tx, ty)) begin
      clip_window(sx, sy, tx, ty, x1, x2, y1, y2);
      for (y = y1; y <= y2; y++) begin
        for (x = x1; x <= x2; x++) begin
          if (!src_written[pix_addr(sf, sx + x, sy + y)])
            queue_write(FUNC_WR_SRC, sf, sx + x, sy + y, random_pixel());
          if (!tgt_written[pix_addr(tf, tx + x, ty + y)])
            queue_write(FUNC_WR_TGT, tf, tx + x, ty + y, random_pixel());
        end
      end
    end
    pending_words.push_back(pack_word(FUNC_QUERY, sf, sx, sy, $urandom, tf, tx, ty, thr));
  endtask

  task automatic queue_unused_word();
    pending_words.push_back(pack_word(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom, $urandom, $urandom));
  endtask

  // Query with centres mostly in a small hot corner so the loaded area stays bounded.
  task automatic random_query();
    int w, h, rad, span, hi_x, hi_y, tx, ty, sx, sy, pick;
    w = eff_w();
    h = eff_h();
    rad = reg_r;
    span = (rad >= 8) ? 4 : 16;
    if ($urandom_range(0, 9) == 0 || w - 1 - rad < rad || h - 1 - rad < rad) begin
      tx = $urandom_range(0, 127);
      ty = $urandom_range(0, 127);
    end else begin
      hi_x = imin(w - 1 - rad, rad + span);
      hi_y = imin(h - 1 - rad, rad + span);
      tx = $urandom_range(rad, hi_x);
      ty = $urandom_range(rad, hi_y);
    end
    sx = imin(127, imax(0, tx + $urandom_range(0, 6) - 3));
    sy = imin(127, imax(0, ty + $urandom_range(0, 6) - 3));
    pick = $urandom_range(0, 9);
    if (pick == 9 && w < MAX_WIDTH) sx = $urandom_range(w, 127);
    if (pick == 9 && h < MAX_HEIGHT && $urandom_range(0, 1) == 1) sy = $urandom_range(h, 127);
    if (pick == 8 && rad < 8) begin
      sx = $urandom_range(0, 127);
      sy = $urandom_range(0, 127);
    end
    queue_query($urandom, sx, sy, $urandom, tx, ty, random_threshold());
  endtask

  // Random traffic: mostly queries, some stray writes and ignored words.
  task automatic run_random(input int ops);
    int n, roll;
    n = 0;
    while (n < ops) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        queue_unused_word();
      end else begin
        if (roll < 14)
          queue_write($urandom_range(0, 1), $urandom, $urandom_range(0, 127),
                      $urandom_range(0, 127), random_pixel());
        else
          random_query();
        n++;
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    apply_reg(idx, data);
  endtask

  task automatic set_regs(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                          input logic [DIM_W-1:0] r);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_RADIUS, r);
  endtask

  // Wait until every word is taken and every result is back, then let the block go quiet.
  task automatic settle();
    while (pending_words.size() != 0 || in_valid || expected_ssd.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input driver: offers queued words, holding each one while stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) take_word(word_now);
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          word_now <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started once on request.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_go && !hold_taken) begin
      hold_left <= LONG_HOLD;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: each accepted word is checked against the oldest expectation.
  always @(posedge clk) begin
    ssd_result_t exp_res;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_ssd.size() == 0) begin
          note_failure($sformatf("unexpected result: distance %0d outcome %0d",
                                 distance, outcome));
        end else begin
          exp_res = expected_ssd.pop_front();
          if (distance !== exp_res.distance || outcome !== exp_res.outcome)
            note_failure($sformatf(
              "result %0d: expected distance %0d outcome %0d, got distance %0d outcome %0d",
              results_seen, exp_res.distance, exp_res.outcome, distance, outcome));
        end
      end
      out_stall <= (hold_left > 1) || ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Register reset values: edge rejections on all four sides, clipped corners.
    queue_write(FUNC_WR_SRC, 2'd3, 127, 127, 24'hFFFFFF);
    queue_write(FUNC_WR_TGT, 2'd0, 0, 0, 24'h000000);
    queue_query(2'd0, 60, 60, 2'd0, 2, 60, ALL_ONES);
    queue_query(2'd0, 60, 60, 2'd0, 125, 60, ALL_ONES);
    queue_query(2'd0, 60, 60, 2'd0, 60, 2, ALL_ONES);
    queue_query(2'd0, 60, 60, 2'd0, 60, 125, ALL_ONES);
    queue_query(2'd3, 127, 127, 2'd3, 127, 127, ALL_ONES);
    queue_query(2'd3, 127, 127, 2'd3, 124, 124, ALL_ONES);
    queue_query(2'd0, 0, 0, 2'd0, 3, 3, 28'd0);
    queue_query(2'd1, 127, 0, 2'd2, 124, 3, random_threshold());
    pending_words.push_back(pack_word(FUNC_UNUSED, '1, '1, '1, '1, '1, '1, '1, '1));
    settle();

    // Single-pixel patches: threshold boundary, empty window, right edge, largest sum.
    write_reg(REG_WIDTH, 8'd64);
    write_reg(REG_RADIUS, 8'd0);
    queue_write(FUNC_WR_SRC, 2'd1, 10, 20, 24'h000000);
    queue_write(FUNC_WR_TGT, 2'd2, 30, 40, 24'h0A0000);
    queue_query(2'd1, 10, 20, 2'd2, 30, 40, 28'd100);
    queue_query(2'd1, 10, 20, 2'd2, 30, 40, 28'd99);
    queue_query(2'd1, 10, 20, 2'd2, 30, 40, ALL_ONES);
    queue_query(2'd1, 100, 20, 2'd2, 30, 40, 28'd0);
    queue_query(2'd1, 63, 20, 2'd2, 63, 40, ALL_ONES);
    queue_query(2'd1, 63, 20, 2'd2, 64, 40, ALL_ONES);
    queue_write(FUNC_WR_SRC, 2'd0, 0, 0, 24'hFFFFFF);
    queue_write(FUNC_WR_TGT, 2'd3, 63, 127, 24'h000000);
    queue_query(2'd0, 0, 0, 2'd3, 63, 127, ALL_ONES);
    settle();

    // Small frame with a sparse sender.
    set_regs(8'd16, 8'd12, 8'd2);
    sender_idle_pct = 84;
    run_random(200);
    settle();

    // Busy receiver, then a full drain before the next burst.
    set_regs(8'd128, 8'd128, 8'd1);
    sender_idle_pct = 0;
    receiver_stall_pct = 84;
    run_random(120);
    settle();

    // Receiver holds off for a long stretch while the sender keeps offering.
    receiver_stall_pct = 0;
    hold_go <= 1'b1;
    run_random(150);
    settle();

    // Oversized width saturates; upper radius bits are dropped.
    set_regs(8'd200, 8'd32, 8'hF5);
    sender_idle_pct = 6;
    receiver_stall_pct = 6;
    run_random(250);
    settle();

    // One-pixel frame.
    set_regs(8'd1, 8'd1, 8'd0);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    run_random(80);
    settle();

    // Zero width saturates to one, so every query is rejected.
    set_regs(8'd0, 8'd255, 8'd15);
    receiver_stall_pct = 84;
    run_random(40);
    settle();

    // Largest radius.
    set_regs(8'd40, 8'd40, 8'd15);
    sender_idle_pct = 6;
    receiver_stall_pct = 6;
    run_random(25);
    settle();

    set_regs(8'd128, 8'd128, 8'd7);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    run_random(200);
    settle();

    set_regs(8'd96, 8'd128, 8'd3);
    sender_idle_pct = 84;
    run_random(200);
    settle();

    $display("Run covered %0d input words, %0d queries (%0d rejected, %0d overrun).",
             words_taken, queries_taken, rejects_seen, overruns_seen);
    $display("Results checked: %0d; register writes: %0d; failures: %0d.",
             results_seen, reg_writes, fail_count);
    if (fail_count == 0 && expected_ssd.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/psd_pkg.sv
hdl/psd_ram.sv
hdl/psd_window.sv
hdl/patch_ssd_distance_top.sv
test/patch_ssd_distance_top_tb.sv
